>>> design/rpf_pkg.sv
// rpf_pkg: constants, types and helpers for the RGBW packet fader.
// No dependencies; imported by rgbw_packet_fader.
package rpf_pkg;

    localparam int unsigned ANNOUNCE_PERIOD   = 10000;
    localparam int unsigned NUM_CHANNELS      = 4;
    localparam int unsigned LEVEL_W           = 8;
    localparam int unsigned NODE_W            = 8;
    localparam int unsigned ACTION_W          = 8;
    localparam int unsigned COUNT_W           = 32;
    localparam int unsigned SPAN_W            = 9;   // interval + 1, up to 256
    localparam int unsigned BITCNT_W          = $clog2(COUNT_W);
    localparam int unsigned RES_W             = (ANNOUNCE_PERIOD > 1) ?
                                                $clog2(ANNOUNCE_PERIOD) : 1;

    localparam logic [ACTION_W-1:0] ACTION_SET_VALUES = ACTION_W'(1);
    localparam logic                MODE_TICK         = 1'b0;
    localparam logic                MODE_PACKET       = 1'b1;

    typedef logic [LEVEL_W-1:0] t_level;

    // one step of a level toward its target
    function automatic t_level step_toward(input t_level cur, input t_level tgt);
        t_level res;
        res = cur;
        if (cur < tgt) begin
            res = cur + t_level'(1);
        end else if (cur > tgt) begin
            res = cur - t_level'(1);
        end
        return res;
    endfunction

endpackage

>>> design/rgbw_packet_fader.sv
// Four-channel RGBW level fader with a bit-serial remainder unit.
// Depends on rpf_pkg.
//
// A packet beat or a tick beat that needs no fade check goes straight into
// the result register. A tick beat while a fade is in progress (interval
// nonzero) runs the shift-subtract remainder unit, one dividend bit per cycle
// over the 32-bit tick count: accept, 32 remainder steps, then write-back,
// which waits for a free result register. The announce flag comes from a
// residue counter that follows the tick count modulo the announce period. A
// new beat is taken only when the block is idle and the result register is
// free or being drained in the same cycle.
module rgbw_packet_fader (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rpf_pkg::NODE_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic [rpf_pkg::NODE_W-1:0] i_dest_node,
    input  logic [rpf_pkg::ACTION_W-1:0] i_action,
    input  logic [rpf_pkg::LEVEL_W-1:0] i_red_target,
    input  logic [rpf_pkg::LEVEL_W-1:0] i_green_target,
    input  logic [rpf_pkg::LEVEL_W-1:0] i_blue_target,
    input  logic [rpf_pkg::LEVEL_W-1:0] i_white_target,
    input  logic [rpf_pkg::LEVEL_W-1:0] i_fade_interval,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rpf_pkg::LEVEL_W-1:0] o_red_level,
    output logic [rpf_pkg::LEVEL_W-1:0] o_green_level,
    output logic [rpf_pkg::LEVEL_W-1:0] o_blue_level,
    output logic [rpf_pkg::LEVEL_W-1:0] o_white_level,
    output logic                       o_announce_due
);
    import rpf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]          r_state,    n_state;
    logic [NODE_W-1:0]   r_own_node, n_own_node;
    logic [COUNT_W-1:0]  r_count,    n_count;
    logic [RES_W-1:0]    r_res,      n_res;
    t_level              r_cur [NUM_CHANNELS];
    t_level              n_cur [NUM_CHANNELS];
    t_level              r_tgt [NUM_CHANNELS];
    t_level              n_tgt [NUM_CHANNELS];
    t_level              r_interval, n_interval;
    logic                r_due,      n_due;

    // remainder unit
    logic [COUNT_W-1:0]  r_dvd,      n_dvd;
    logic [SPAN_W-1:0]   r_rem,      n_rem;
    logic [SPAN_W-1:0]   r_span,     n_span;
    logic [BITCNT_W-1:0] r_bit,      n_bit;

    // result register
    logic                r_out_valid, n_out_valid;
    t_level              r_out [NUM_CHANNELS];
    t_level              n_out [NUM_CHANNELS];
    logic                r_out_due,  n_out_due;

    logic                out_free;
    logic                accept;
    logic [SPAN_W:0]     trial;
    t_level              pkt_tgt [NUM_CHANNELS];

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign trial    = {r_rem, r_dvd[COUNT_W-1]};

    assign pkt_tgt[0] = i_red_target;
    assign pkt_tgt[1] = i_green_target;
    assign pkt_tgt[2] = i_blue_target;
    assign pkt_tgt[3] = i_white_target;

    always_comb begin
        n_state     = r_state;
        n_own_node  = i_cfg_we ? i_cfg_data : r_own_node;
        n_count     = r_count;
        n_res       = r_res;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_interval  = r_interval;
        n_due       = r_due;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_span      = r_span;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        n_out_due   = r_out_due;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_PACKET) begin
                        if (i_dest_node == r_own_node && i_action == ACTION_SET_VALUES) begin
                            n_interval = i_fade_interval;
                            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                                n_tgt[ch] = pkt_tgt[ch];
                                if (i_fade_interval == '0) begin
                                    n_cur[ch] = pkt_tgt[ch];
                                end
                            end
                        end
                        n_out       = n_cur;
                        n_out_due   = 1'b0;
                        n_out_valid = 1'b1;
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                        // residue restarts whenever the count wraps to zero
                        if (n_count == '0 || r_res == RES_W'(ANNOUNCE_PERIOD - 1)) begin
                            n_res = '0;
                        end else begin
                            n_res = r_res + RES_W'(1);
                        end
                        n_due = (n_res == '0);
                        if (r_interval == '0) begin
                            n_out       = r_cur;
                            n_out_due   = n_due;
                            n_out_valid = 1'b1;
                        end else begin
                            n_dvd   = n_count;
                            n_rem   = '0;
                            n_span  = SPAN_W'(r_interval) + SPAN_W'(1);
                            n_bit   = BITCNT_W'(COUNT_W - 1);
                            n_state = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_span}) begin
                    n_rem = SPAN_W'(trial - {1'b0, r_span});
                end else begin
                    n_rem = trial[SPAN_W-1:0];
                end
                n_dvd = {r_dvd[COUNT_W-2:0], 1'b0};
                n_bit = r_bit - BITCNT_W'(1);
                if (r_bit == '0) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (out_free) begin
                    if (r_rem == '0) begin
                        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                            n_cur[ch] = step_toward(r_cur[ch], r_tgt[ch]);
                        end
                    end
                    n_out       = n_cur;
                    n_out_due   = r_due;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_own_node  <= NODE_W'(1);
            r_count     <= '0;
            r_res       <= '0;
            r_interval  <= '0;
            r_due       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r_cur[ch] <= '0;
                r_tgt[ch] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_own_node  <= n_own_node;
            r_count     <= n_count;
            r_res       <= n_res;
            r_interval  <= n_interval;
            r_due       <= n_due;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_span    <= n_span;
        r_bit     <= n_bit;
        r_out     <= n_out;
        r_out_due <= n_out_due;
    end

    assign o_valid        = r_out_valid;
    assign o_red_level    = r_out[0];
    assign o_green_level  = r_out[1];
    assign o_blue_level   = r_out[2];
    assign o_white_level  = r_out[3];
    assign o_announce_due = r_out_due;

endmodule
